// File: rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, constants and the sine table of the Poisson-disc point sampler.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int MAP_WIDTH_DEF  = 512;
  localparam int MAP_HEIGHT_DEF = 512;
  localparam int MIN_DIST_DEF   = 8;
  localparam int TRIALS_DEF     = 5;

  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;
  localparam int GRID_DW     = 13;
  localparam int SINE_W      = 17;
  localparam int SINE_N      = 91;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_TRIAL   = 1'b1;

  localparam logic CFG_START_X = 1'b0;
  localparam logic CFG_START_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_TAKEN    = 3'd2,
    ST_CLOSE    = 3'd3,
    ST_FINISHED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PARENT, S_BOUND, S_DIV1, S_DIV2, S_ADDR, S_CENTER_RD,
    S_CENTER, S_NB_SEL, S_NB_GRID, S_NB_PT, S_COMMIT, S_DONE
  } state_e;

  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [11:0] idx;
    status_e     status;
  } result_t;

  // quarter-wave sine in q1.16, evaluated by a fixed-point taylor series
  function automatic logic [SINE_N*SINE_W-1:0] build_sine_table();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    logic [SINE_N*SINE_W-1:0] t;
    t = '0;
    for (int d = 0; d < SINE_N; d++) begin
      x    = (longint'(d) * 64'd3373259426 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      // series terms x^(2n+1) / (2n+1)!, each from the previous one
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd342;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd420;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      q = (longint'(sum) + 64'd8192) >> 14;
      if (q > 64'd65536) q = 64'd65536;
      t[d*SINE_W +: SINE_W] = SINE_W'(q);
    end
    return t;
  endfunction

  localparam logic [SINE_N*SINE_W-1:0] SINE_TABLE = build_sine_table();

  // returns {negative, magnitude} of the sine of a whole-degree angle 0..359
  function automatic logic [SINE_W:0] sine_lookup(logic [8:0] a);
    logic [8:0] i;
    logic       neg;
    if (a <= 9'd90) begin
      i = a; neg = 1'b0;
    end else if (a <= 9'd180) begin
      i = 9'd180 - a; neg = 1'b0;
    end else if (a <= 9'd270) begin
      i = a - 9'd180; neg = 1'b1;
    end else begin
      i = 9'd360 - a; neg = 1'b1;
    end
    return {neg, SINE_TABLE[int'(i)*SINE_W +: SINE_W]};
  endfunction

endpackage

// File: rtl/poisson_disc_point_sampler_top.sv
// ----------------------------------------------------------------------------
// poisson_disc_point_sampler_top
// Blue-noise point placement on a background cell grid, stream interfaces.
//
//   channel   direction  payload
//   s_axis    in         tdata: radius_offset, angle_deg; tuser: operation
//   m_axis    out        tdata: point_x, point_y, point_index, status
//   cfg       in         start_x (index 0), start_y (index 1)
//
// a trial reads the parent and checks the bound, and ends there when the
// candidate leaves the map; else it finds the cell, reads the centre cell, visits
// up to eight neighbour cells (select, grid read and point read per occupied one),
// commits and shows the result, on one memory port each. a restart first sweeps
// the cell grid, one cell a cycle (GRID_CELLS cells, 4096 at the defaults); the
// same sweep runs after reset, and no transaction is taken while it runs. one
// result is buffered, so the next item is taken while a result waits on m_axis.
// ----------------------------------------------------------------------------
module poisson_disc_point_sampler_top import pds_pkg::*; #(
  parameter int MAP_WIDTH         = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT        = MAP_HEIGHT_DEF,
  parameter int MIN_DIST          = MIN_DIST_DEF,
  parameter int TRIALS_PER_PARENT = TRIALS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [2:0] radius_offset, [11:3] angle_deg
  input  logic [0:0]  s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [8:0] x, [17:9] y, [29:18] index, [32:30] status
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i
);

  logic [8:0] start_x_q, start_y_q;
  logic       res_valid, res_ready;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i[0])
        CFG_START_X: start_x_q <= cfg_wdata_i;
        CFG_START_Y: start_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pds_core #(
    .MAP_WIDTH        (MAP_WIDTH),
    .MAP_HEIGHT       (MAP_HEIGHT),
    .MIN_DIST         (MIN_DIST),
    .TRIALS_PER_PARENT(TRIALS_PER_PARENT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser[0]),
    .in_offset_i(s_axis_tdata[2:0]),
    .in_angle_i (s_axis_tdata[11:3]),
    .start_x_i  (start_x_q),
    .start_y_i  (start_y_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.status, out_q.idx, out_q.y, out_q.x};

endmodule

// File: rtl/pds_ram.sv
// ----------------------------------------------------------------------------
// pds_ram
// Single-port synchronous ram with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/pds_core.sv
// ----------------------------------------------------------------------------
// pds_core
// Sequencer around the point store and the cell grid: candidate generation,
// cell lookup, neighbour distance checks, write-back and the grid clear on restart.
// ----------------------------------------------------------------------------
module pds_core import pds_pkg::*; #(
  parameter int MAP_WIDTH         = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT        = MAP_HEIGHT_DEF,
  parameter int MIN_DIST          = MIN_DIST_DEF,
  parameter int TRIALS_PER_PARENT = TRIALS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_op_i,
  input  logic [2:0] in_offset_i,
  input  logic [8:0] in_angle_i,
  input  logic [8:0] start_x_i,
  input  logic [8:0] start_y_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  localparam int XW        = $clog2(MAP_WIDTH);
  localparam int YW        = $clog2(MAP_HEIGHT);
  localparam int MW        = (XW > YW) ? XW : YW;
  localparam int CW        = ((MW > 7) ? MW : 7) + 2;
  localparam int SW        = XW + YW;
  localparam int RADW      = $clog2(2 * MIN_DIST);
  localparam int TW        = $clog2(TRIALS_PER_PARENT + 1);
  localparam int GRID_COLS = (MAP_WIDTH + MIN_DIST - 1) / MIN_DIST;
  localparam int GRID_ROWS = (MAP_HEIGHT + MIN_DIST - 1) / MIN_DIST;
  localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
  localparam int GAW       = $clog2(GRID_CELLS);
  localparam int DIV_SH    = CW + 6;
  localparam int PW        = CW + DIV_SH + 1;
  localparam logic [PW-1:0] RECIP = PW'((64'd1 << DIV_SH) / MIN_DIST);
  localparam int DSW       = 2 * CW + 4;

  state_e state_q, state_d;

  logic [12:0]          count_q, parent_q;
  logic [TW-1:0]        trial_q;
  logic                 restart_q;
  logic [8:0]           ang_q;
  logic [RADW-1:0]      rad_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [CW-1:0]        q0x_q, q0y_q;
  logic [XW-1:0]        cc_q;
  logic [YW-1:0]        cr_q;
  logic [GAW-1:0]       center_q, clr_q;
  logic [1:0]           nr_q, nc_q;
  result_t              res_q;

  logic                 grid_we, store_we;
  logic [GAW-1:0]       grid_addr;
  logic [GRID_DW-1:0]   grid_wdata, grid_rdata;
  logic [STORE_AW-1:0]  store_addr;
  logic [SW-1:0]        store_wdata, store_rdata;

  pds_ram #(.DEPTH(GRID_CELLS), .AW(GAW), .DW(GRID_DW)) u_grid (
    .clk_i  (clk_i),
    .we_i   (grid_we),
    .addr_i (grid_addr),
    .wdata_i(grid_wdata),
    .rdata_o(grid_rdata)
  );

  pds_ram #(.DEPTH(STORE_DEPTH), .AW(STORE_AW), .DW(SW)) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .addr_i (store_addr),
    .wdata_i(store_wdata),
    .rdata_o(store_rdata)
  );

  // ---- combinational datapath ----
  logic [8:0]           ang_red;
  logic [9:0]           cos_sum;
  logic [8:0]           cos_ang;
  logic [2:0]           off_sat;
  logic [SINE_W:0]      sin_l, cos_l;
  logic [22:0]          prod_x, prod_y;
  logic signed [CW-1:0] offx, offy;
  logic [12:0]          sx_cl, sy_cl;
  logic                 outside;
  logic [XW-1:0]        clx;
  logic [YW-1:0]        cly;
  logic [PW-1:0]        dprod_x, dprod_y;
  logic [CW-1:0]        remx, remy;
  logic                 row_ok, col_ok;
  logic signed [GAW+1:0] nb_lin;
  logic [GAW-1:0]       nb_addr;
  logic [GAW+YW:0]      center_lin;
  logic signed [CW:0]   dx, dy;
  logic [DSW-1:0]       dsq;
  logic                 trial_ok;
  logic                 nb_done;

  always_comb begin
    ang_red = (in_angle_i >= 9'd360) ? in_angle_i - 9'd360 : in_angle_i;
    off_sat = (32'(in_offset_i) > MIN_DIST - 1) ? 3'(MIN_DIST - 1) : in_offset_i;
    cos_sum = 10'(ang_q) + 10'd90;
  end

  function automatic logic [8:0] cos_ang_f(logic [9:0] s);
    return (s >= 10'd360) ? 9'(s - 10'd360) : 9'(s);
  endfunction

  always_comb begin
    cos_ang = cos_ang_f(cos_sum);
    sin_l   = sine_lookup(ang_q);
    cos_l   = sine_lookup(cos_ang);
    prod_x  = 23'(rad_q) * 23'(sin_l[SINE_W-1:0]) + 23'd32768;
    prod_y  = 23'(rad_q) * 23'(cos_l[SINE_W-1:0]) + 23'd32768;
    offx    = sin_l[SINE_W] ? -CW'($signed({1'b0, prod_x[22:16]}))
                            : CW'($signed({1'b0, prod_x[22:16]}));
    offy    = cos_l[SINE_W] ? -CW'($signed({1'b0, prod_y[22:16]}))
                            : CW'($signed({1'b0, prod_y[22:16]}));

    sx_cl = (13'(start_x_i) >= 13'(MAP_WIDTH)) ? 13'(MAP_WIDTH - 1) : 13'(start_x_i);
    sy_cl = (13'(start_y_i) >= 13'(MAP_HEIGHT)) ? 13'(MAP_HEIGHT - 1) : 13'(start_y_i);

    outside = (cx_q < 0) || (cx_q >= CW'(MAP_WIDTH)) ||
              (cy_q < 0) || (cy_q >= CW'(MAP_HEIGHT));
    if (cx_q < 0) clx = '0;
    else if (cx_q >= CW'(MAP_WIDTH)) clx = XW'(MAP_WIDTH - 1);
    else clx = XW'(cx_q);
    if (cy_q < 0) cly = '0;
    else if (cy_q >= CW'(MAP_HEIGHT)) cly = YW'(MAP_HEIGHT - 1);
    else cly = YW'(cy_q);

    // cell = coord / MIN_DIST by reciprocal, corrected by one step
    dprod_x = PW'(unsigned'(cx_q)) * RECIP;
    dprod_y = PW'(unsigned'(cy_q)) * RECIP;
    remx    = CW'(unsigned'(cx_q)) - CW'(q0x_q * CW'(MIN_DIST));
    remy    = CW'(unsigned'(cy_q)) - CW'(q0y_q * CW'(MIN_DIST));

    center_lin = (GAW+YW+1)'(cr_q) * (GAW+YW+1)'(GRID_COLS) + (GAW+YW+1)'(cc_q);

    row_ok = (nr_q == 2'd1) || ((nr_q == 2'd0) && (cr_q != '0)) ||
             ((nr_q == 2'd2) && (32'(cr_q) + 1 < GRID_ROWS));
    col_ok = (nc_q == 2'd1) || ((nc_q == 2'd0) && (cc_q != '0)) ||
             ((nc_q == 2'd2) && (32'(cc_q) + 1 < GRID_COLS));
    nb_lin = $signed({2'b00, center_q});
    if (nr_q == 2'd2) nb_lin = nb_lin + (GAW+2)'(GRID_COLS);
    if (nr_q == 2'd0) nb_lin = nb_lin - (GAW+2)'(GRID_COLS);
    if (nc_q == 2'd2) nb_lin = nb_lin + (GAW+2)'(1);
    if (nc_q == 2'd0) nb_lin = nb_lin - (GAW+2)'(1);
    nb_addr = GAW'(nb_lin);
    nb_done = (nr_q == 2'd3);

    dx  = (CW+1)'(cx_q) - $signed({1'b0, (CW)'(store_rdata[XW-1:0])});
    dy  = (CW+1)'(cy_q) - $signed({1'b0, (CW)'(store_rdata[SW-1:XW])});
    dsq = DSW'(dx * dx) + DSW'(dy * dy);

    trial_ok = parent_q < count_q;
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (clr_q == GAW'(GRID_CELLS - 1)) state_d = restart_q ? S_DIV1 : S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_RESTART) state_d = S_CLEAR;
          else if (trial_ok) state_d = S_PARENT;
          else state_d = S_DONE;
        end
      end
      S_PARENT:    state_d = S_BOUND;
      S_BOUND:     state_d = outside ? S_DONE : S_DIV1;
      S_DIV1:      state_d = S_DIV2;
      S_DIV2:      state_d = S_ADDR;
      S_ADDR:      state_d = restart_q ? S_COMMIT : S_CENTER_RD;
      S_CENTER_RD: state_d = S_CENTER;
      S_CENTER:    state_d = (grid_rdata != '0) ? S_DONE : S_NB_SEL;
      S_NB_SEL: begin
        if (nb_done) state_d = S_COMMIT;
        else if (row_ok && col_ok) state_d = S_NB_GRID;
      end
      S_NB_GRID: begin
        if (grid_rdata != '0 && grid_rdata <= GRID_DW'(STORE_DEPTH)) state_d = S_NB_PT;
        else state_d = S_NB_SEL;
      end
      S_NB_PT:     state_d = (dsq <= DSW'(MIN_DIST * MIN_DIST)) ? S_DONE : S_NB_SEL;
      S_COMMIT:    state_d = S_DONE;
      S_DONE:      if (res_ready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // ---- outputs and memory controls ----
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    res_o       = res_q;
    grid_we     = 1'b0;
    grid_addr   = center_q;
    grid_wdata  = '0;
    store_we    = 1'b0;
    store_addr  = parent_q[STORE_AW-1:0];
    store_wdata = {YW'(cy_q), XW'(cx_q)};
    case (state_q)
      S_CLEAR: begin
        grid_we   = 1'b1;
        grid_addr = clr_q;
      end
      S_NB_SEL:  grid_addr = nb_addr;
      S_NB_GRID: store_addr = STORE_AW'(grid_rdata - GRID_DW'(1));
      S_COMMIT: begin
        if (restart_q) begin
          grid_we    = 1'b1;
          grid_wdata = GRID_DW'(1);
          store_we   = 1'b1;
          store_addr = '0;
        end else if (count_q < 13'(STORE_DEPTH)) begin
          grid_we    = 1'b1;
          grid_wdata = count_q + 13'd1;
          store_we   = 1'b1;
          store_addr = count_q[STORE_AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      count_q   <= '0;
      parent_q  <= '0;
      trial_q   <= '0;
      restart_q <= 1'b0;
      clr_q     <= '0;
      nr_q      <= '0;
      nc_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + GAW'(1);
        S_IDLE: begin
          clr_q <= '0;
          nr_q  <= '0;
          nc_q  <= '0;
          if (in_valid_i) begin
            restart_q <= (in_op_i == OP_RESTART);
            if (in_op_i == OP_TRIAL && trial_ok) begin
              if (32'(trial_q) + 1 >= TRIALS_PER_PARENT) begin
                trial_q  <= '0;
                parent_q <= parent_q + 13'd1;
              end else begin
                trial_q <= trial_q + TW'(1);
              end
            end
          end
        end
        S_NB_SEL: begin
          if (!nb_done && !(row_ok && col_ok)) begin
            if (nc_q == 2'd2) begin
              nc_q <= '0; nr_q <= nr_q + 2'd1;
            end else nc_q <= nc_q + 2'd1;
          end
        end
        S_NB_GRID, S_NB_PT: begin
          if (state_d == S_NB_SEL) begin
            if (nc_q == 2'd2) begin
              nc_q <= '0; nr_q <= nr_q + 2'd1;
            end else nc_q <= nc_q + 2'd1;
          end
        end
        S_COMMIT: begin
          if (restart_q) begin
            count_q  <= 13'd1;
            parent_q <= '0;
            trial_q  <= '0;
          end else if (count_q < 13'(STORE_DEPTH)) begin
            count_q <= count_q + 13'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ang_q <= ang_red;
        rad_q <= RADW'(MIN_DIST) + RADW'(off_sat);
        cx_q  <= CW'($signed({1'b0, sx_cl}));
        cy_q  <= CW'($signed({1'b0, sy_cl}));
        res_q <= '{x: 9'd0, y: 9'd0, idx: 12'd0, status: ST_FINISHED};
      end
      S_PARENT: begin
        cx_q <= $signed({1'b0, (CW-1)'(store_rdata[XW-1:0])}) + offx;
        cy_q <= $signed({1'b0, (CW-1)'(store_rdata[SW-1:XW])}) + offy;
      end
      S_BOUND: begin
        res_q.x      <= 9'(clx);
        res_q.y      <= 9'(cly);
        res_q.status <= ST_OUTSIDE;
      end
      S_DIV1: begin
        q0x_q <= CW'(dprod_x >> DIV_SH);
        q0y_q <= CW'(dprod_y >> DIV_SH);
      end
      S_DIV2: begin
        cc_q <= XW'((remx >= CW'(MIN_DIST)) ? q0x_q + CW'(1) : q0x_q);
        cr_q <= YW'((remy >= CW'(MIN_DIST)) ? q0y_q + CW'(1) : q0y_q);
      end
      S_ADDR:   center_q <= GAW'(center_lin);
      S_CENTER: res_q.status <= ST_TAKEN;
      S_NB_PT:  res_q.status <= ST_CLOSE;
      S_COMMIT: begin
        res_q.x <= 9'(clx);
        res_q.y <= 9'(cly);
        if (restart_q) begin
          res_q.idx    <= '0;
          res_q.status <= ST_ACCEPTED;
        end else if (count_q < 13'(STORE_DEPTH)) begin
          res_q.idx    <= count_q[11:0];
          res_q.status <= ST_ACCEPTED;
        end else begin
          res_q.status <= ST_FINISHED;
        end
      end
      default: ;
    endcase
  end

endmodule
